FILE: design/srcc_pkg.sv
`default_nettype none

package srcc_pkg;

	// frame kinds, same code on mode and frame_type
	localparam logic [1:0] KIND_MEAS   = 2'd0;
	localparam logic [1:0] KIND_STATUS = 2'd1;
	localparam logic [1:0] KIND_SERIAL = 2'd2;

	// CRC-8, MSB first, no final xor
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// frame lengths in bytes
	localparam logic [2:0] LEN_SHORT = 3'd3;
	localparam logic [2:0] LEN_LONG  = 3'd6;

	// byte positions inside a frame
	localparam logic [2:0] POS_W0_HI  = 3'd0;
	localparam logic [2:0] POS_W0_LO  = 3'd1;
	localparam logic [2:0] POS_W0_CRC = 3'd2;
	localparam logic [2:0] POS_W1_HI  = 3'd3;
	localparam logic [2:0] POS_W1_LO  = 3'd4;
	localparam logic [2:0] POS_W1_CRC = 3'd5;

	// conversion scale factors
	localparam logic [14:0] TEMP_SCALE  = 15'd17500;
	localparam logic [13:0] HUM_SCALE   = 14'd10000;
	localparam logic [16:0] TEMP_OFFSET = 17'd4500;

	// one byte through the CRC register
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: design/sensor_reply_crc_check_convert_core.sv
// Channel  Dir  tdata                               tuser
// s_*      in   [7:0] rx_byte                       [0] frame_start, [2:1] mode
// m_*      out  [14:0] temperature_centi,           [1:0] frame_type, [2] crc_error
//               [28:15] humidity_centi,
//               [44:29] status_value,
//               [76:45] serial_value, [79:77] zero
//
// One byte beat per cycle while s_tready is high; after the last byte of its frame
// a result passes the input register, frame logic, multipliers and divide by 65535.
// The stages are elastic: each takes a new beat when it is empty or moving on.
// arst_n clears all valid flags and the frame and held-value state.
// A stalled m_* side fills the stages, then drops s_tready.
`default_nettype none

module sensor_reply_crc_check_convert_core import srcc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic [2:0]  s_tuser,   // [0] frame_start, [2:1] mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,   // temperature, humidity, status, serial
	output logic [2:0]       m_tuser    // [1:0] frame_type, [2] crc_error
);

	// stage valids and elastic readies
	logic v1_q, v2_q, v3_q;
	logic out_free, r3, r2, r1;

	assign out_free = !m_tvalid || m_tready;
	assign r3       = !v3_q || out_free;
	assign r2       = !v2_q || r3;
	assign r1       = !v1_q || r2;
	assign s_tready = r1;

	// input register
	logic [7:0] byte_s1;
	logic       start_s1;
	logic [1:0] mode_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (r1) begin
			v1_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (r1 && s_tvalid) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser[0];
			mode_s1  <= s_tuser[2:1];
		end
	end

	// frame state
	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [1:0]  kind_q;
	logic [15:0] word0_q, word1_q;
	logic        err_q;

	logic [2:0]  pos_b;
	logic [7:0]  crc_b, crc_n;
	logic [1:0]  kind_b;
	logic [15:0] word0_b, word1_b, word0_n, word1_n;
	logic        err_b, err_n;
	logic [2:0]  len;
	logic        active, done, step;

	assign step = v1_q && r2;

	// frame start restarts the state; reserved mode saturates to serial
	always_comb begin
		pos_b   = start_s1 ? 3'd0 : pos_q;
		crc_b   = start_s1 ? CRC_INIT : crc_q;
		err_b   = start_s1 ? 1'b0 : err_q;
		word0_b = start_s1 ? 16'd0 : word0_q;
		word1_b = start_s1 ? 16'd0 : word1_q;
		kind_b  = start_s1 ? ((mode_s1 > KIND_SERIAL) ? KIND_SERIAL : mode_s1) : kind_q;
		len     = (kind_b == KIND_STATUS) ? LEN_SHORT : LEN_LONG;
		active  = pos_b < len;
		done    = active && ((pos_b + 3'd1) == len);
	end

	// per-byte CRC and word assembly
	always_comb begin
		crc_n   = crc_b;
		err_n   = err_b;
		word0_n = word0_b;
		word1_n = word1_b;
		unique case (pos_b)
			POS_W0_HI: begin
				crc_n   = crc8_byte(CRC_INIT, byte_s1);
				word0_n = {byte_s1, word0_b[7:0]};
			end
			POS_W0_LO: begin
				crc_n   = crc8_byte(crc_b, byte_s1);
				word0_n = {word0_b[15:8], byte_s1};
			end
			POS_W1_HI: begin
				crc_n   = crc8_byte(CRC_INIT, byte_s1);
				word1_n = {byte_s1, word1_b[7:0]};
			end
			POS_W1_LO: begin
				crc_n   = crc8_byte(crc_b, byte_s1);
				word1_n = {word1_b[15:8], byte_s1};
			end
			POS_W0_CRC, POS_W1_CRC: begin
				err_n = err_b || (crc_b != byte_s1);
				crc_n = CRC_INIT;
			end
			default: begin
				crc_n = crc_b;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 3'd0;
			crc_q   <= CRC_INIT;
			kind_q  <= KIND_MEAS;
			word0_q <= 16'd0;
			word1_q <= 16'd0;
			err_q   <= 1'b0;
		end else if (step) begin
			kind_q  <= kind_b;
			pos_q   <= active ? pos_b + 3'd1 : pos_b;
			crc_q   <= active ? crc_n : crc_b;
			err_q   <= active ? err_n : err_b;
			word0_q <= active ? word0_n : word0_b;
			word1_q <= active ? word1_n : word1_b;
		end
	end

	// completed frame
	logic [1:0]  kind_s2;
	logic        err_s2;
	logic [15:0] word0_s2, word1_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else if (r2) begin
			v2_q <= step && done;
		end
	end

	always_ff @(posedge clk) begin
		if (step && done) begin
			kind_s2  <= kind_b;
			err_s2   <= err_n;
			word0_s2 <= word0_n;
			word1_s2 <= word1_n;
		end
	end

	// scale products
	logic [1:0]  kind_s3;
	logic        err_s3;
	logic [15:0] word0_s3, word1_s3;
	logic [30:0] prod_t_s3;
	logic [29:0] prod_h_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_q <= 1'b0;
		end else if (r3) begin
			v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (r3 && v2_q) begin
			kind_s3   <= kind_s2;
			err_s3    <= err_s2;
			word0_s3  <= word0_s2;
			word1_s3  <= word1_s2;
			prod_t_s3 <= {15'd0, word0_s2} * {16'd0, TEMP_SCALE};
			prod_h_s3 <= {14'd0, word1_s2} * {16'd0, HUM_SCALE};
		end
	end

	// divide by 65535: q = (x + (x >> 16) + 1) >> 16
	logic [31:0] sum_t, back_t;
	logic [15:0] quo_t;
	logic        rem_nz, neg_t;
	logic [16:0] temp_w;
	logic [30:0] sum_h;
	logic [14:0] quo_h;

	always_comb begin
		sum_t  = {1'b0, prod_t_s3} + {17'd0, prod_t_s3[30:16]} + 32'd1;
		quo_t  = sum_t[31:16];
		back_t = {quo_t, 16'd0} - {16'd0, quo_t};
		rem_nz = back_t != {1'b0, prod_t_s3};
		// below the offset the result rounds toward zero, i.e. up
		neg_t  = {1'b0, quo_t} < TEMP_OFFSET;
		temp_w = {1'b0, quo_t} - TEMP_OFFSET + {16'd0, neg_t && rem_nz};
		sum_h  = {1'b0, prod_h_s3} + {17'd0, prod_h_s3[29:16]} + 31'd1;
		quo_h  = sum_h[30:16];
	end

	// held values and result register
	logic [14:0] held_temp_q;
	logic [13:0] held_hum_q;
	logic        meas_ok, load_out;
	logic [14:0] temp_out;
	logic [13:0] hum_out;
	logic [15:0] status_out;
	logic [31:0] serial_out;

	assign load_out = v3_q && out_free;

	always_comb begin
		meas_ok    = (kind_s3 == KIND_MEAS) && !err_s3;
		temp_out   = meas_ok ? temp_w[14:0] : held_temp_q;
		hum_out    = meas_ok ? quo_h[13:0] : held_hum_q;
		status_out = ((kind_s3 == KIND_STATUS) && !err_s3) ? word0_s3 : 16'd0;
		serial_out = ((kind_s3 == KIND_SERIAL) && !err_s3) ? {word0_s3, word1_s3} : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_temp_q <= 15'd0;
			held_hum_q  <= 14'd0;
			m_tvalid    <= 1'b0;
		end else begin
			if (out_free) begin
				m_tvalid <= v3_q;
			end
			if (load_out) begin
				held_temp_q <= temp_out;
				held_hum_q  <= hum_out;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata <= {3'd0, serial_out, status_out, hum_out, temp_out};
			m_tuser <= {err_s3, kind_s3};
		end
	end

endmodule

`default_nettype wire
